// File: rtl/agk_pkg.sv
// Shared types, constants and helpers for the angle and gyro bias Kalman filter.
`default_nettype none
package agk_pkg;

    localparam int DATA_W        = 32;
    localparam int NOISE_W       = 31;
    localparam int DT_W          = 24;
    localparam int COV_FRAC_BITS = 24;
    localparam int DT_FRAC_BITS  = 24;
    localparam int OP_A_W        = DATA_W + 2;
    localparam int OP_B_W        = DATA_W + 1;
    localparam int PROD_W        = OP_A_W + OP_B_W;
    localparam int ACC_W         = PROD_W + 1;
    localparam int CFG_IDX_W     = 2;

    localparam logic signed [DATA_W-1:0] COV_ONE = DATA_W'(64'd1 << COV_FRAC_BITS);
    localparam logic [NOISE_W-1:0] ANGLE_NOISE_RST =
        NOISE_W'(((64'd1 << COV_FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [NOISE_W-1:0] BIAS_NOISE_RST =
        NOISE_W'(((64'd3 << COV_FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [NOISE_W-1:0] MEASURE_NOISE_RST =
        NOISE_W'(64'd1 << (COV_FRAC_BITS - 1));
    localparam logic [DT_W-1:0] STEP_TIME_RST = DT_W'(83886);

    localparam logic signed [ACC_W-1:0] HALF_COV = ACC_W'(64'd1 << (COV_FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] HALF_DT  = ACC_W'(64'd1 << (DT_FRAC_BITS - 1));

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ANGLE_NOISE   = 2'd0,
        REG_BIAS_NOISE    = 2'd1,
        REG_MEASURE_NOISE = 2'd2,
        REG_STEP_TIME     = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic start;
        logic sub;
        logic cov_shift;
    } mac_req_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-DATA_W:0] top;
        top = v[ACC_W-1:DATA_W-1];
        if (top == '0 || top == '1)
        begin
            return v[DATA_W-1:0];
        end
        else if (v[ACC_W-1])
        begin
            return SAT_MIN;
        end
        else
        begin
            return SAT_MAX;
        end
    endfunction

endpackage
`default_nettype wire

// File: rtl/angle_gyro_kalman_filter.sv
// Top level of the two-state angle and gyro bias Kalman filter with its sequencer.
`default_nettype none
// One input transfer (angle_meas, rate_meas, signed Q16.16) yields one result transfer
// (angle_est, rate_est). An item runs through these steps, from its input transfer to the
// load of its result: the transfer, eleven passes through the shared multiply-accumulate
// unit, one decision state, two runs of the serial gain divider and the output load; when
// the innovation variance is not positive the divisions are skipped. in_ready is high only
// while no item is in flight; a finished result is held in the output register, so the
// next input may be transferred while it waits. Configuration writes are always taken
// and belong to idle periods; reset restores the default noise settings, step time and
// state.
module angle_gyro_kalman_filter
    import agk_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic signed [DATA_W-1:0]  angle_meas,
    input  wire logic signed [DATA_W-1:0]  rate_meas,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic signed [DATA_W-1:0]       angle_est,
    output logic signed [DATA_W-1:0]       rate_est,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [DATA_W-1:0]         cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_PREP,
        S_DIV0_GO,
        S_DIV0_WAIT,
        S_DIV1_GO,
        S_DIV1_WAIT,
        S_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_PRED_ANGLE,
        OP_PRED_C00,
        OP_PRED_C01,
        OP_PRED_C10,
        OP_PRED_C11,
        OP_UPD_C00,
        OP_UPD_C01,
        OP_UPD_C10,
        OP_UPD_C11,
        OP_UPD_ANGLE,
        OP_UPD_BIAS
    } op_t;

    state_t state_reg;
    op_t    op_reg;

    logic [NOISE_W-1:0] angle_noise_reg;
    logic [NOISE_W-1:0] bias_noise_reg;
    logic [NOISE_W-1:0] measure_noise_reg;
    logic [DT_W-1:0]    step_time_reg;

    logic signed [DATA_W-1:0] angle_reg;
    logic signed [DATA_W-1:0] bias_reg;
    logic signed [DATA_W-1:0] c00_reg;
    logic signed [DATA_W-1:0] c01_reg;
    logic signed [DATA_W-1:0] c10_reg;
    logic signed [DATA_W-1:0] c11_reg;
    logic signed [DATA_W-1:0] am_reg;
    logic signed [DATA_W-1:0] rm_reg;
    logic signed [DATA_W-1:0] err_reg;
    logic signed [DATA_W-1:0] k0_reg;
    logic signed [DATA_W-1:0] k1_reg;
    logic signed [DATA_W-1:0] t0_reg;
    logic signed [DATA_W-1:0] t1_reg;
    logic [DATA_W-1:0]        e_reg;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] angle_est_reg;
    logic signed [DATA_W-1:0] rate_est_reg;

    mac_req_t                 mac_req;
    logic signed [OP_A_W-1:0] mac_a;
    logic signed [OP_B_W-1:0] mac_b;
    logic signed [DATA_W-1:0] mac_acc;
    logic                     mac_done;
    logic signed [DATA_W-1:0] mac_res;

    logic                     div_start;
    logic signed [DATA_W-1:0] div_num;
    logic                     div_done;
    logic signed [DATA_W-1:0] div_quo;

    logic signed [OP_B_W-1:0] dt_s;
    logic signed [DATA_W:0]   rc;
    logic signed [DATA_W:0]   e_full;
    logic                     e_pos;
    logic signed [DATA_W-1:0] err_val;
    logic signed [DATA_W-1:0] rate_out;

    assign dt_s     = $signed({{(OP_B_W - DT_W){1'b0}}, step_time_reg});
    assign rc       = (DATA_W + 1)'(rm_reg) - (DATA_W + 1)'(bias_reg);
    assign e_full   = $signed({2'b00, measure_noise_reg}) + (DATA_W + 1)'(c00_reg);
    assign e_pos    = !e_full[DATA_W] && (e_full != '0);
    assign err_val  = sat32(ACC_W'(am_reg) - ACC_W'(angle_reg));
    assign rate_out = sat32(ACC_W'(rm_reg) - ACC_W'(bias_reg));

    always_comb
    begin
        mac_req.start     = (state_reg == S_ISSUE);
        mac_req.sub       = 1'b0;
        mac_req.cov_shift = 1'b0;
        mac_a             = OP_A_W'(rc);
        mac_b             = dt_s;
        mac_acc           = angle_reg;
        unique case (op_reg)
            OP_PRED_ANGLE:
            begin
                mac_a   = OP_A_W'(rc);
                mac_acc = angle_reg;
            end
            OP_PRED_C00:
            begin
                mac_a   = $signed({{(OP_A_W - NOISE_W){1'b0}}, angle_noise_reg})
                          - OP_A_W'(c01_reg) - OP_A_W'(c10_reg);
                mac_acc = c00_reg;
            end
            OP_PRED_C01:
            begin
                mac_a   = -OP_A_W'(c11_reg);
                mac_acc = c01_reg;
            end
            OP_PRED_C10:
            begin
                mac_a   = -OP_A_W'(c11_reg);
                mac_acc = c10_reg;
            end
            OP_PRED_C11:
            begin
                mac_a   = $signed({{(OP_A_W - NOISE_W){1'b0}}, bias_noise_reg});
                mac_acc = c11_reg;
            end
            OP_UPD_C00:
            begin
                mac_req.sub       = 1'b1;
                mac_req.cov_shift = 1'b1;
                mac_a             = OP_A_W'(k0_reg);
                mac_b             = OP_B_W'(t0_reg);
                mac_acc           = c00_reg;
            end
            OP_UPD_C01:
            begin
                mac_req.sub       = 1'b1;
                mac_req.cov_shift = 1'b1;
                mac_a             = OP_A_W'(k0_reg);
                mac_b             = OP_B_W'(t1_reg);
                mac_acc           = c01_reg;
            end
            OP_UPD_C10:
            begin
                mac_req.sub       = 1'b1;
                mac_req.cov_shift = 1'b1;
                mac_a             = OP_A_W'(k1_reg);
                mac_b             = OP_B_W'(t0_reg);
                mac_acc           = c10_reg;
            end
            OP_UPD_C11:
            begin
                mac_req.sub       = 1'b1;
                mac_req.cov_shift = 1'b1;
                mac_a             = OP_A_W'(k1_reg);
                mac_b             = OP_B_W'(t1_reg);
                mac_acc           = c11_reg;
            end
            OP_UPD_ANGLE:
            begin
                mac_req.cov_shift = 1'b1;
                mac_a             = OP_A_W'(k0_reg);
                mac_b             = OP_B_W'(err_reg);
                mac_acc           = angle_reg;
            end
            OP_UPD_BIAS:
            begin
                mac_req.cov_shift = 1'b1;
                mac_a             = OP_A_W'(k1_reg);
                mac_b             = OP_B_W'(err_reg);
                mac_acc           = bias_reg;
            end
            default:
            begin
                mac_a   = OP_A_W'(rc);
                mac_acc = angle_reg;
            end
        endcase
    end

    assign div_start = (state_reg == S_DIV0_GO) || (state_reg == S_DIV1_GO);
    assign div_num   = (state_reg == S_DIV1_GO) ? c10_reg : c00_reg;

    agk_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mac_req),
        .op_a  (mac_a),
        .op_b  (mac_b),
        .acc   (mac_acc),
        .done  (mac_done),
        .res   (mac_res)
    );

    agk_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (e_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            op_reg            <= OP_PRED_ANGLE;
            angle_noise_reg   <= ANGLE_NOISE_RST;
            bias_noise_reg    <= BIAS_NOISE_RST;
            measure_noise_reg <= MEASURE_NOISE_RST;
            step_time_reg     <= STEP_TIME_RST;
            angle_reg         <= '0;
            bias_reg          <= '0;
            c00_reg           <= COV_ONE;
            c01_reg           <= '0;
            c10_reg           <= '0;
            c11_reg           <= COV_ONE;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_ANGLE_NOISE:   angle_noise_reg   <= cfg_data[NOISE_W-1:0];
                    REG_BIAS_NOISE:    bias_noise_reg    <= cfg_data[NOISE_W-1:0];
                    REG_MEASURE_NOISE: measure_noise_reg <= cfg_data[NOISE_W-1:0];
                    REG_STEP_TIME:     step_time_reg     <= cfg_data[DT_W-1:0];
                    default:           step_time_reg     <= step_time_reg;
                endcase
            end

            if (out_valid_reg && out_ready && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg    <= OP_PRED_ANGLE;
                        state_reg <= S_ISSUE;
                    end
                end
                S_ISSUE:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (mac_done)
                    begin
                        state_reg <= S_ISSUE;
                        unique case (op_reg)
                            OP_PRED_ANGLE:
                            begin
                                angle_reg <= mac_res;
                                op_reg    <= OP_PRED_C00;
                            end
                            OP_PRED_C00:
                            begin
                                c00_reg <= mac_res;
                                op_reg  <= OP_PRED_C01;
                            end
                            OP_PRED_C01:
                            begin
                                c01_reg <= mac_res;
                                op_reg  <= OP_PRED_C10;
                            end
                            OP_PRED_C10:
                            begin
                                c10_reg <= mac_res;
                                op_reg  <= OP_PRED_C11;
                            end
                            OP_PRED_C11:
                            begin
                                c11_reg   <= mac_res;
                                state_reg <= S_PREP;
                            end
                            OP_UPD_C00:
                            begin
                                c00_reg <= mac_res;
                                op_reg  <= OP_UPD_C01;
                            end
                            OP_UPD_C01:
                            begin
                                c01_reg <= mac_res;
                                op_reg  <= OP_UPD_C10;
                            end
                            OP_UPD_C10:
                            begin
                                c10_reg <= mac_res;
                                op_reg  <= OP_UPD_C11;
                            end
                            OP_UPD_C11:
                            begin
                                c11_reg <= mac_res;
                                op_reg  <= OP_UPD_ANGLE;
                            end
                            OP_UPD_ANGLE:
                            begin
                                angle_reg <= mac_res;
                                op_reg    <= OP_UPD_BIAS;
                            end
                            OP_UPD_BIAS:
                            begin
                                bias_reg  <= mac_res;
                                state_reg <= S_OUT;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_PREP:
                begin
                    op_reg <= OP_UPD_C00;
                    if (e_pos)
                    begin
                        state_reg <= S_DIV0_GO;
                    end
                    else
                    begin
                        state_reg <= S_ISSUE;
                    end
                end
                S_DIV0_GO:
                begin
                    state_reg <= S_DIV0_WAIT;
                end
                S_DIV0_WAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_DIV1_GO;
                    end
                end
                S_DIV1_GO:
                begin
                    state_reg <= S_DIV1_WAIT;
                end
                S_DIV1_WAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_ISSUE;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            am_reg <= angle_meas;
            rm_reg <= rate_meas;
        end
        if (state_reg == S_PREP)
        begin
            err_reg <= err_val;
            e_reg   <= e_full[DATA_W-1:0];
            t0_reg  <= c00_reg;
            t1_reg  <= c01_reg;
            k0_reg  <= '0;
            k1_reg  <= '0;
        end
        if (state_reg == S_DIV0_WAIT && div_done)
        begin
            k0_reg <= div_quo;
        end
        if (state_reg == S_DIV1_WAIT && div_done)
        begin
            k1_reg <= div_quo;
        end
        if (state_reg == S_OUT && (!out_valid_reg || out_ready))
        begin
            angle_est_reg <= angle_reg;
            rate_est_reg  <= rate_out;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign angle_est = angle_est_reg;
    assign rate_est  = rate_est_reg;

endmodule
`default_nettype wire

// File: rtl/agk_mac.sv
// Shared pipelined multiply, round, accumulate and saturate unit.
`default_nettype none
module agk_mac
    import agk_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire mac_req_t                  req,
    input  wire logic signed [OP_A_W-1:0]  op_a,
    input  wire logic signed [OP_B_W-1:0]  op_b,
    input  wire logic signed [DATA_W-1:0]  acc,
    output logic                           done,
    output logic signed [DATA_W-1:0]       res
);

    logic signed [OP_A_W-1:0] a_reg;
    logic signed [OP_B_W-1:0] b_reg;
    logic signed [DATA_W-1:0] acc_reg;
    logic signed [DATA_W-1:0] acc2_reg;
    logic                     sub_reg;
    logic                     sub2_reg;
    logic                     cs_reg;
    logic                     cs2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [DATA_W-1:0] res_reg;
    logic                     v0_reg;
    logic                     v1_reg;
    logic                     done_reg;

    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] cov_rnd;
    logic signed [ACC_W-1:0] dt_rnd;
    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-1:0] acc_ext;
    logic signed [ACC_W-1:0] sum;

    assign prod_ext = ACC_W'(prod_reg);
    assign cov_rnd  = (prod_ext + HALF_COV) >>> COV_FRAC_BITS;
    assign dt_rnd   = (prod_ext + HALF_DT) >>> DT_FRAC_BITS;
    assign rnd      = cs2_reg ? cov_rnd : dt_rnd;
    assign acc_ext  = ACC_W'(acc2_reg);
    assign sum      = sub2_reg ? (acc_ext - rnd) : (acc_ext + rnd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v0_reg   <= req.start;
            v1_reg   <= v0_reg;
            done_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= op_a;
            b_reg   <= op_b;
            acc_reg <= acc;
            sub_reg <= req.sub;
            cs_reg  <= req.cov_shift;
        end
        if (v0_reg)
        begin
            prod_reg <= PROD_W'(a_reg) * PROD_W'(b_reg);
            acc2_reg <= acc_reg;
            sub2_reg <= sub_reg;
            cs2_reg  <= cs_reg;
        end
        if (v1_reg)
        begin
            res_reg <= sat32(sum);
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule
`default_nettype wire

// File: rtl/agk_div.sv
// Serial restoring divider for the Kalman gains, one quotient bit per cycle.
`default_nettype none
module agk_div
    import agk_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic signed [DATA_W-1:0]  num,
    input  wire logic [DATA_W-1:0]         den,
    output logic                           done,
    output logic signed [DATA_W-1:0]       quo
);

    localparam int NUM_W = DATA_W + COV_FRAC_BITS;
    localparam int Q_W   = DATA_W - 1;
    localparam int HI_W  = NUM_W - Q_W;
    localparam int CNT_W = $clog2(Q_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(Q_W - 1);

    logic                     busy_reg;
    logic                     done_reg;
    logic                     neg_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [DATA_W-1:0]        rem_reg;
    logic [Q_W-1:0]           low_reg;
    logic [Q_W-1:0]           qm_reg;
    logic [DATA_W-1:0]        den_reg;
    logic signed [DATA_W-1:0] quo_reg;

    logic [DATA_W-1:0] mag;
    logic [NUM_W-1:0]  numw;
    logic [HI_W-1:0]   hi;
    logic              ovf;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;
    logic              qbit;
    logic [Q_W-1:0]    qm_next;

    assign mag     = num[DATA_W-1] ? DATA_W'(-num) : DATA_W'(num);
    assign numw    = {mag, {COV_FRAC_BITS{1'b0}}};
    assign hi      = numw[NUM_W-1:Q_W];
    assign ovf     = {{(DATA_W + 1 - HI_W){1'b0}}, hi} >= {1'b0, den};
    assign trial   = {rem_reg, low_reg[Q_W-1]};
    assign diff    = trial - {1'b0, den_reg};
    assign qbit    = !diff[DATA_W];
    assign qm_next = {qm_reg[Q_W-2:0], qbit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= !ovf;
                done_reg <= ovf;
            end
            else if (busy_reg && cnt_reg == LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[DATA_W-1];
            den_reg <= den;
            rem_reg <= {{(DATA_W - HI_W){1'b0}}, hi};
            low_reg <= numw[Q_W-1:0];
            qm_reg  <= '0;
            cnt_reg <= '0;
            quo_reg <= num[DATA_W-1] ? SAT_MIN : SAT_MAX;
        end
        else if (busy_reg)
        begin
            rem_reg <= qbit ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
            low_reg <= {low_reg[Q_W-2:0], 1'b0};
            qm_reg  <= qm_next;
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == LAST)
            begin
                quo_reg <= neg_reg ? -$signed({1'b0, qm_next}) : $signed({1'b0, qm_next});
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule
`default_nettype wire

// File: bench/testbench.sv
// Self-checking bench for the angle and gyro bias Kalman filter: directed table, then random IMU traffic.
`timescale 1ns / 1ps
module testbench;
    import agk_pkg::*;

    localparam int     WATCHDOG_LIMIT = 20000;
    localparam int     RANDOM_ITEMS   = 1880;
    localparam int     PHASE_ITEMS    = 235;
    localparam int     HOLD_AT        = 600;
    localparam int     HOLD_CYCLES    = 1500;
    localparam int     SETTLE_CYCLES  = 150;
    localparam int     MAX_REPORTS    = 10;
    localparam longint UNIT           = 64'sd16777216;

    localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S_MIN = 32'sh8000_0000;

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;
    typedef enum logic [1:0] {MIX_TYPICAL, MIX_EXTREME, MIX_WILD, MIX_DEFAULT} cfg_mix_t;
    typedef enum logic [1:0] {STALL_NONE, STALL_HALF, STALL_RARE, STALL_PERIODIC} stall_mode_t;

    typedef struct packed {
        logic signed [31:0] angle;
        logic signed [31:0] rate;
    } estimate_t;

    typedef struct packed {
        row_kind_t          kind;
        cfg_reg_t           reg_idx;
        logic [31:0]        reg_data;
        logic signed [31:0] angle;
        logic signed [31:0] rate;
        logic               known;
        estimate_t          want;
    } stim_row_t;

    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     in_valid   = 1'b0;
    logic                     in_ready;
    logic signed [DATA_W-1:0] angle_meas = '0;
    logic signed [DATA_W-1:0] rate_meas  = '0;
    logic                     out_valid;
    logic                     out_ready  = 1'b0;
    logic signed [DATA_W-1:0] angle_est;
    logic signed [DATA_W-1:0] rate_est;
    logic                     cfg_valid  = 1'b0;
    logic                     cfg_ready;
    cfg_reg_t                 cfg_index  = REG_ANGLE_NOISE;
    logic [DATA_W-1:0]        cfg_data   = '0;

    logic [30:0]        angle_q = 31'd16777;
    logic [30:0]        bias_q  = 31'd50332;
    logic [30:0]        meas_r  = 31'd8388608;
    logic [23:0]        dt_s    = 24'd83886;
    logic signed [31:0] tilt_x  = '0;
    logic signed [31:0] drift_x = '0;
    logic signed [31:0] p00     = 32'sd16777216;
    logic signed [31:0] p01     = '0;
    logic signed [31:0] p10     = '0;
    logic signed [31:0] p11     = 32'sd16777216;

    estimate_t predicted_estimates[$];
    stim_row_t script[$];
    int        results_due  = 0;
    int        results_seen = 0;
    int        items_in     = 0;
    int        fails        = 0;
    int        burst_left   = 0;
    int        quiet_cycles = 0;

    angle_gyro_kalman_filter i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .angle_meas (angle_meas),
        .rate_meas  (rate_meas),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .angle_est  (angle_est),
        .rate_est   (rate_est),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > longint'(S_MAX))
        begin
            return S_MAX;
        end
        if (v < longint'(S_MIN))
        begin
            return S_MIN;
        end
        return v[31:0];
    endfunction

    function automatic longint round_shift(input longint v, input int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic estimate_t filter_step(input logic signed [31:0] am,
                                              input logic signed [31:0] rm);
        longint             dt, rc, pd0, m11, e, k0, k1, err, t0, t1;
        logic signed [31:0] n00, n01, n10, n11;
        estimate_t          r;
        dt     = longint'(dt_s);
        rc     = longint'(rm) - longint'(drift_x);
        tilt_x = clamp32(longint'(tilt_x) + round_shift(rc * dt, 24));
        pd0    = longint'(angle_q) - longint'(p01) - longint'(p10);
        m11    = -longint'(p11);
        p00    = clamp32(longint'(p00) + round_shift(pd0 * dt, 24));
        p01    = clamp32(longint'(p01) + round_shift(m11 * dt, 24));
        p10    = clamp32(longint'(p10) + round_shift(m11 * dt, 24));
        p11    = clamp32(longint'(p11) + round_shift(longint'(bias_q) * dt, 24));
        err    = longint'(clamp32(longint'(am) - longint'(tilt_x)));
        e      = longint'(meas_r) + longint'(p00);
        k0     = 0;
        k1     = 0;
        if (e > 0)
        begin
            k0 = longint'(clamp32((longint'(p00) * UNIT) / e));
            k1 = longint'(clamp32((longint'(p10) * UNIT) / e));
        end
        t0  = longint'(p00);
        t1  = longint'(p01);
        n00 = clamp32(longint'(p00) - round_shift(k0 * t0, 24));
        n01 = clamp32(longint'(p01) - round_shift(k0 * t1, 24));
        n10 = clamp32(longint'(p10) - round_shift(k1 * t0, 24));
        n11 = clamp32(longint'(p11) - round_shift(k1 * t1, 24));
        p00 = n00;
        p01 = n01;
        p10 = n10;
        p11 = n11;
        tilt_x  = clamp32(longint'(tilt_x) + round_shift(k0 * err, 24));
        drift_x = clamp32(longint'(drift_x) + round_shift(k1 * err, 24));
        r.angle = tilt_x;
        r.rate  = clamp32(longint'(rm) - longint'(drift_x));
        return r;
    endfunction

    function automatic void apply_reg(input cfg_reg_t idx, input logic [31:0] data);
        case (idx)
            REG_ANGLE_NOISE:   angle_q = data[30:0];
            REG_BIAS_NOISE:    bias_q  = data[30:0];
            REG_MEASURE_NOISE: meas_r  = data[30:0];
            default:           dt_s    = data[23:0];
        endcase
    endfunction

    function automatic logic [31:0] reg_value(input cfg_reg_t idx, input cfg_mix_t mix);
        int pick;
        pick = $urandom_range(0, 2);
        case (mix)
            MIX_EXTREME:
            begin
                return (pick == 0) ? 32'h0 : (pick == 1) ? 32'h1 : 32'hFFFF_FFFF;
            end
            MIX_WILD:
            begin
                return $urandom;
            end
            MIX_DEFAULT:
            begin
                case (idx)
                    REG_ANGLE_NOISE:   return 32'd16777;
                    REG_BIAS_NOISE:    return 32'd50332;
                    REG_MEASURE_NOISE: return 32'd8388608;
                    default:           return 32'd83886;
                endcase
            end
            default:
            begin
                case (idx)
                    REG_ANGLE_NOISE:   return $urandom_range(0, 1 << 20);
                    REG_BIAS_NOISE:    return $urandom_range(0, 1 << 20);
                    REG_MEASURE_NOISE: return $urandom_range(1 << 16, 1 << 26);
                    default:           return $urandom_range(1, 1 << 19);
                endcase
            end
        endcase
    endfunction

    function automatic logic signed [31:0] corner_value();
        case ($urandom_range(0, 4))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return 32'sd0;
            3:       return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    function automatic void row_item(input logic signed [31:0] am, input logic signed [31:0] rm,
                                     input logic known = 1'b0, input estimate_t want = '0);
        stim_row_t row;
        row         = '0;
        row.kind    = ROW_ITEM;
        row.angle   = am;
        row.rate    = rm;
        row.known   = known;
        row.want    = want;
        script.push_back(row);
    endfunction

    function automatic void row_reg(input cfg_reg_t idx, input logic [31:0] data);
        stim_row_t row;
        row          = '0;
        row.kind     = ROW_REG;
        row.reg_idx  = idx;
        row.reg_data = data;
        script.push_back(row);
    endfunction

    function automatic void note_failure(input string msg);
        fails++;
        if (fails <= MAX_REPORTS)
        begin
            $display("%s", msg);
        end
    endfunction

    function automatic void check_field(input string name, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
        if (got !== want)
        begin
            note_failure($sformatf("mismatch on %s, result %0d: expected %0d (0x%08h), got %0d (0x%08h)",
                                   name, results_seen, want, want, got, got));
        end
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_item(input logic signed [31:0] am, input logic signed [31:0] rm,
                             input logic known, input estimate_t want);
        int        gap;
        estimate_t predicted;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        angle_meas <= am;
        rate_meas  <= rm;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = filter_step(am, rm);
        predicted_estimates.push_back(known ? want : predicted);
        results_due++;
        items_in++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        wait (results_due == 0);
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin : receiver
        stall_mode_t mode;
        int          mode_left;
        int          hold_left;
        int          tick;
        logic        held;
        estimate_t   want;
        mode      = STALL_NONE;
        mode_left = 200;
        hold_left = 0;
        tick      = 0;
        held      = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (predicted_estimates.size() == 0)
                begin
                    note_failure($sformatf("result %0d arrived with nothing expected", results_seen));
                end
                else
                begin
                    want = predicted_estimates.pop_front();
                    results_due--;
                    check_field("angle_est", want.angle, angle_est);
                    check_field("rate_est", want.rate, rate_est);
                end
            end
            // hold off once mid-run so the block backs up into its input
            if (!held && items_in >= HOLD_AT)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = stall_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(50, 400);
                end
                mode_left--;
                tick++;
                case (mode)
                    STALL_NONE: out_ready <= 1'b1;
                    STALL_HALF: out_ready <= 1'($urandom_range(0, 1));
                    STALL_RARE: out_ready <= ($urandom_range(0, 7) == 0);
                    default:    out_ready <= (tick % 5 == 0);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        stim_row_t row;
        cfg_mix_t  mix;
        int        pick;
        int        tilt;
        int        spin;
        int        offset;
        int        a;
        int        r;
        tilt   = 0;
        spin   = 0;
        offset = 0;

        row_item(32'sd0, 32'sd0, 1'b1, '0);
        row_item(S_MAX, S_MAX);
        row_item(S_MIN, S_MIN);
        row_item(S_MAX, S_MIN);
        row_item(S_MIN, S_MAX);
        row_item(32'sh0001_0000, 32'shFFFF_0000);
        row_item(-32'sd1, 32'sd1);
        // zero step time: prediction is a no-op
        row_reg(REG_STEP_TIME, 32'h0);
        row_item(32'sh005A_0000, 32'sh0010_0000);
        row_item(32'shFFA6_0000, 32'shFFF0_0000);
        // zero measurement noise leaves the innovation variance equal to the predicted p00 alone
        row_reg(REG_MEASURE_NOISE, 32'h0);
        row_item(32'sh0002_0000, 32'sh0000_8000);
        row_item(32'shFFFE_0000, 32'sh0000_4000);
        row_item(S_MAX, S_MIN);
        row_item(32'sh0000_1234, 32'shFFFF_EDCC);
        // all-ones data: upper bits must be dropped, covariance saturates
        row_reg(REG_ANGLE_NOISE, 32'hFFFF_FFFF);
        row_reg(REG_BIAS_NOISE, 32'hFFFF_FFFF);
        row_reg(REG_MEASURE_NOISE, 32'h7FFF_FFFF);
        row_reg(REG_STEP_TIME, 32'hFFFF_FFFF);
        row_item(S_MAX, S_MAX);
        row_item(S_MIN, S_MIN);
        row_item(S_MAX, S_MIN);
        row_item(32'sd0, 32'sd0);
        row_item(S_MIN, S_MAX);
        row_reg(REG_ANGLE_NOISE, 32'h0);
        row_reg(REG_BIAS_NOISE, 32'h0);
        row_reg(REG_MEASURE_NOISE, 32'h1);
        row_reg(REG_STEP_TIME, 32'h1);
        row_item(32'sh0010_0000, 32'sh0001_0000);
        row_item(32'shFFF0_0000, S_MIN);
        row_item(32'sd0, S_MAX);
        for (int k = 0; k < 4; k++)
            row_reg(cfg_reg_t'(k), reg_value(cfg_reg_t'(k), MIX_DEFAULT));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            row = script[i];
            if (row.kind == ROW_REG)
            begin
                if (i > 0 && script[i-1].kind == ROW_ITEM)
                    drain();
                write_reg(row.reg_idx, row.reg_data);
            end
            else
            begin
                send_item(row.angle, row.rate, row.known, row.want);
            end
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % PHASE_ITEMS == 0)
            begin
                drain();
                pick = $urandom_range(0, 7);
                mix  = (pick < 5) ? MIX_TYPICAL : cfg_mix_t'(pick - 4);
                for (int k = 0; k < 4; k++)
                    write_reg(cfg_reg_t'(k), reg_value(cfg_reg_t'(k), mix));
                offset = int'($urandom_range(0, 10 << 16)) - (5 << 16);
            end
            pick = $urandom_range(0, 19);
            if (pick < 3)
            begin
                a = $urandom;
                r = $urandom;
            end
            else if (pick == 3)
            begin
                a = corner_value();
                r = corner_value();
            end
            else
            begin
                // smooth tilt trajectory with gyro offset and noise; occasional jump
                if (pick == 4)
                    tilt = int'($urandom_range(0, 180 << 16)) - (90 << 16);
                spin = spin + int'($urandom_range(0, 1 << 17)) - (1 << 16);
                if (spin > (250 << 16))
                    spin = 250 << 16;
                if (spin < -(250 << 16))
                    spin = -(250 << 16);
                tilt = tilt + (spin >>> 8);
                if (tilt > (90 << 16))
                    tilt = 90 << 16;
                if (tilt < -(90 << 16))
                    tilt = -(90 << 16);
                a = tilt + int'($urandom_range(0, 1 << 17)) - (1 << 16);
                r = spin + offset + int'($urandom_range(0, 1 << 15)) - (1 << 14);
            end
            send_item(a, r, 1'b0, '0);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (predicted_estimates.size() != 0)
            note_failure($sformatf("%0d results never arrived", predicted_estimates.size()));
        if (fails == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
rtl/agk_pkg.sv
rtl/agk_mac.sv
rtl/agk_div.sv
rtl/angle_gyro_kalman_filter.sv
bench/testbench.sv
